// ===== design/pgmb_pkg.sv =====
// Shared types and constants of the polar grid minimum-height binner.
// Holds the controller/datapath command and status structs and the CORDIC angle table.
// No dependencies.
package pgmb_pkg;

   localparam int DEFAULT_CHANNELS   = 128;
   localparam int DEFAULT_BINS       = 128;
   localparam int DEFAULT_COORD_BITS = 16;

   localparam int MUL_W        = 32;
   localparam int D2_W         = 2 * MUL_W;
   localparam int CORDIC_STEPS = 16;
   localparam int PHASE_W      = 33;
   localparam int ANGLE_W      = 36;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RANGE_W    = 15;
   localparam int HEIGHT_W   = 16;
   localparam int CELL_W     = 7;
   localparam int RSP_W      = 48;

   localparam logic [RANGE_W-1:0]         MIN_RANGE_RST = 15'd340;
   localparam logic [RANGE_W-1:0]         MAX_RANGE_RST = 15'd12000;
   localparam logic signed [HEIGHT_W-1:0] FLOOR_RST     = -16'sd200;
   localparam logic signed [HEIGHT_W-1:0] CEILING_RST   = -16'sd40;
   localparam logic signed [HEIGHT_W-1:0] SENSOR_RST    = 16'sd200;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_EMPTY  = 16'sh7FFF;

   localparam logic [31:0] ANGLE_TAB [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_RANGE = 3'd0,
      REG_MAX_RANGE = 3'd1,
      REG_FLOOR     = 3'd2,
      REG_CEILING   = 3'd3,
      REG_SENSOR    = 3'd4
   } csr_reg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_D2,
      OP_RMIN,
      OP_RMAX,
      OP_SLO,
      OP_SHI,
      OP_SCALE,
      OP_EDGE,
      OP_ESQ,
      OP_STEP,
      OP_ADDR,
      OP_READ,
      OP_WRITE,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_read;
      logic out_range;
      logic search_done;
      logic cordic_done;
      logic ch_ok;
      logic clear_last;
   } dp_status_type;

endpackage

// ===== design/polar_grid_min_height_binner.sv =====
// Top level of the polar grid minimum-height binner.
// Instantiates pgmb_ctrl and pgmb_datapath; depends on pgmb_pkg.
//
// Each request either inserts a point or reads and clears one grid cell. An insert
// whose planar range lies strictly inside (min_range, max_range) is mapped to an
// angular channel (16-step CORDIC, one rotation per cycle) and a radial bin (exact
// binary search, one bin bit per pass through its check, edge, square and step states);
// the cell keeps its lowest z. A read returns the cell's lowest z, the clamped ground
// height and an empty flag, then empties the cell. One request is in flight at a time;
// an out-of-range insert skips the bin search. The response register lets the next
// request enter while a result still waits. After reset the cell memory is swept empty,
// one cell per cycle, over all CHANNELS*BINS cells (16384 by default); no request is
// taken during that sweep, register writes are. Write registers only while idle.
module polar_grid_min_height_binner #(
   parameter int CHANNELS   = pgmb_pkg::DEFAULT_CHANNELS,
   parameter int BINS       = pgmb_pkg::DEFAULT_BINS,
   parameter int COORD_BITS = pgmb_pkg::DEFAULT_COORD_BITS,
   localparam int REQ_W     = ((3 * COORD_BITS + 2 * pgmb_pkg::CELL_W + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // x_pos, y_pos, z_pos, cell_channel, cell_bin (lowest bit up), zero filled
   input  logic [REQ_W-1:0]                     req_tdata,
   // command: 0 insert point, 1 read and clear cell
   input  logic                                 req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // accepted, channel_index, bin_index, lowest_height, ground_height, cell_empty
   output logic [pgmb_pkg::RSP_W-1:0]           rsp_tdata,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pgmb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pgmb_pkg::CSR_DATA_W-1:0]      csr_data
);
   localparam int CB = COORD_BITS;
   localparam int CW = pgmb_pkg::CELL_W;

   pgmb_pkg::dp_cmd_type    cmd;
   pgmb_pkg::dp_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   pgmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .status    (status),
      .cmd       (cmd)
   );

   pgmb_datapath #(
      .CHANNELS   (CHANNELS),
      .BINS       (BINS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .in_command      (req_tuser),
      .in_x            ($signed(req_tdata[CB-1:0])),
      .in_y            ($signed(req_tdata[2*CB-1:CB])),
      .in_z            ($signed(req_tdata[3*CB-1:2*CB])),
      .in_cell_channel (req_tdata[3*CB+CW-1:3*CB]),
      .in_cell_bin     (req_tdata[3*CB+2*CW-1:3*CB+CW]),
      .rsp_data        (rsp_tdata)
   );

   // a rejected insert reports no cell and no heights
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[47:1] == 47'd0)
      else $error("rejected insert carries nonzero fields");

   // an empty cell always reads back the empty marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47] |-> rsp_tdata[30:15] == 16'h7FFF && rsp_tdata[0])
      else $error("empty cell read with wrong lowest height");

   // one request at a time: after a request is taken the port stays closed
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in flight");
endmodule

// ===== design/pgmb_cordic.sv =====
// Iterative vectoring CORDIC: turns a point into a 33-bit fraction of a turn.
// One rotation per cycle from the pgmb_pkg angle table. Depends on pgmb_pkg.
module pgmb_cordic #(
   parameter int COORD_BITS = pgmb_pkg::DEFAULT_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [COORD_BITS-1:0]          x_in,
   input  logic signed [COORD_BITS-1:0]          y_in,
   output logic                                  done,
   output logic [pgmb_pkg::PHASE_W-1:0]          phase
);
   localparam int CW    = COORD_BITS + 19;
   localparam int AW    = pgmb_pkg::ANGLE_W;
   localparam int IDX_W = $clog2(pgmb_pkg::CORDIC_STEPS);
   localparam logic signed [AW-1:0] HALF = AW'(64'h80000000);
   localparam logic [pgmb_pkg::PHASE_W-1:0] FULL_PH = 33'h100000000;
   localparam logic [pgmb_pkg::PHASE_W-1:0] HALF_PH = 33'h080000000;
   localparam logic signed [AW-1:0] TOP = AW'(64'hFFFFFFFF);

   logic                 busy_ff, fin_ff, done_ff;
   logic [IDX_W-1:0]     i_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [AW-1:0] ang_ff, base_ff;
   logic [pgmb_pkg::PHASE_W-1:0] phase_ff;

   logic signed [CW-1:0] xe, ye, xs, ys;
   logic signed [AW-1:0] tab, total;

   assign xe    = CW'(x_in);
   assign ye    = CW'(y_in);
   assign xs    = cx_ff >>> i_ff;
   assign ys    = cy_ff >>> i_ff;
   assign tab   = AW'(pgmb_pkg::ANGLE_TAB[i_ff]);
   assign total = base_ff + ang_ff + HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else if (start) begin
         fin_ff <= 1'b0;
         i_ff   <= '0;
         ang_ff <= '0;
         if (y_in == '0) begin
            // on the x axis: the angle is known without rotation
            phase_ff <= (x_in >= 0) ? HALF_PH : FULL_PH;
            done_ff  <= 1'b1;
            busy_ff  <= 1'b0;
         end else begin
            done_ff <= 1'b0;
            busy_ff <= 1'b1;
            if (x_in < 0) begin
               cx_ff   <= (-xe) <<< 16;
               cy_ff   <= (-ye) <<< 16;
               base_ff <= (y_in > 0) ? HALF : -HALF;
            end else begin
               cx_ff   <= xe <<< 16;
               cy_ff   <= ye <<< 16;
               base_ff <= '0;
            end
         end
      end else if (busy_ff) begin
         if (cy_ff > 0) begin
            cx_ff  <= cx_ff + ys;
            cy_ff  <= cy_ff - xs;
            ang_ff <= ang_ff + tab;
         end else begin
            cx_ff  <= cx_ff - ys;
            cy_ff  <= cy_ff + xs;
            ang_ff <= ang_ff - tab;
         end
         i_ff <= i_ff + 1'b1;
         if (i_ff == IDX_W'(pgmb_pkg::CORDIC_STEPS - 1)) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end else if (fin_ff) begin
         fin_ff  <= 1'b0;
         done_ff <= 1'b1;
         if (total < 0)        phase_ff <= '0;
         else if (total > TOP) phase_ff <= 33'h0FFFFFFFF;
         else                  phase_ff <= pgmb_pkg::PHASE_W'(total);
      end
   end

   assign done  = done_ff;
   assign phase = phase_ff;
endmodule

// ===== design/pgmb_datapath.sv =====
// Datapath: range test, exact bin search, channel from CORDIC phase, cell memory, result.
// Driven by pgmb_ctrl through dp_cmd_type. Depends on pgmb_pkg and pgmb_cordic.
module pgmb_datapath #(
   parameter int CHANNELS   = pgmb_pkg::DEFAULT_CHANNELS,
   parameter int BINS       = pgmb_pkg::DEFAULT_BINS,
   parameter int COORD_BITS = pgmb_pkg::DEFAULT_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pgmb_pkg::dp_cmd_type                  cmd,
   output pgmb_pkg::dp_status_type               status,
   input  logic                                  csr_we,
   input  logic [pgmb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pgmb_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                  in_command,
   input  logic signed [COORD_BITS-1:0]          in_x,
   input  logic signed [COORD_BITS-1:0]          in_y,
   input  logic signed [COORD_BITS-1:0]          in_z,
   input  logic [pgmb_pkg::CELL_W-1:0]           in_cell_channel,
   input  logic [pgmb_pkg::CELL_W-1:0]           in_cell_bin,
   output logic [pgmb_pkg::RSP_W-1:0]            rsp_data
);
   localparam int CH_BITS  = $clog2(CHANNELS);
   localparam int BIN_BITS = $clog2(BINS);
   localparam int DEPTH    = CHANNELS * BINS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int BINSQ    = BINS * BINS;
   localparam int EDGE_W   = 17 + BIN_BITS;
   localparam int BRM_W    = 16 + BIN_BITS;
   localparam int CHX_W    = CH_BITS + 2;
   localparam int CHP_W    = CHX_W + 32;
   localparam int MW       = pgmb_pkg::MUL_W;
   localparam int SC_W     = 3 * MW;
   localparam int HW       = pgmb_pkg::HEIGHT_W;
   localparam int RW       = pgmb_pkg::RANGE_W;

   pgmb_pkg::dp_op_type op;
   assign op = cmd.op;

   // configuration
   logic [RW-1:0]        min_range_ff, max_range_ff;
   logic signed [HW-1:0] floor_ff, ceiling_ff, sensor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= pgmb_pkg::MIN_RANGE_RST;
         max_range_ff <= pgmb_pkg::MAX_RANGE_RST;
         floor_ff     <= pgmb_pkg::FLOOR_RST;
         ceiling_ff   <= pgmb_pkg::CEILING_RST;
         sensor_ff    <= pgmb_pkg::SENSOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pgmb_pkg::REG_MIN_RANGE: min_range_ff <= csr_data[RW-1:0];
            pgmb_pkg::REG_MAX_RANGE: max_range_ff <= csr_data[RW-1:0];
            pgmb_pkg::REG_FLOOR:     floor_ff     <= $signed(csr_data);
            pgmb_pkg::REG_CEILING:   ceiling_ff   <= $signed(csr_data);
            pgmb_pkg::REG_SENSOR:    sensor_ff    <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // request hold
   logic                         read_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   logic [pgmb_pkg::CELL_W-1:0]  cch_ff, cbin_ff;

   // arithmetic registers
   logic [2*MW-1:0]       sqx_ff, sqy_ff, slo_ff, shi_ff;
   logic [pgmb_pkg::D2_W-1:0] d2_ff;
   logic [2*RW-1:0]       rmin2_ff, rmax2_ff;
   logic [BRM_W-1:0]      brmin_ff;
   logic [RW-1:0]         span_ff;
   logic [SC_W-1:0]       scaled_ff;
   logic [BIN_BITS-1:0]   lo_ff, hi_ff;
   logic [EDGE_W-1:0]     edge_ff;
   logic [2*EDGE_W-1:0]   esq_ff;

   logic [COORD_BITS-1:0] ax, ay;
   logic [BIN_BITS:0]     mid_sum;
   logic [BIN_BITS-1:0]   mid;
   logic                  out_range;

   assign ax      = (x_ff < 0) ? COORD_BITS'(-x_ff) : COORD_BITS'(x_ff);
   assign ay      = (y_ff < 0) ? COORD_BITS'(-y_ff) : COORD_BITS'(y_ff);
   assign mid_sum = (BIN_BITS + 1)'(lo_ff) + (BIN_BITS + 1)'(hi_ff) + 1'b1;
   assign mid     = mid_sum[BIN_BITS:1];
   assign out_range = (d2_ff <= pgmb_pkg::D2_W'(rmin2_ff)) ||
                      (d2_ff >= pgmb_pkg::D2_W'(rmax2_ff));

   always_ff @(posedge clock) begin
      case (op)
         pgmb_pkg::OP_LOAD: begin
            read_ff <= in_command;
            x_ff    <= in_x;
            y_ff    <= in_y;
            z_ff    <= in_z;
            cch_ff  <= in_cell_channel;
            cbin_ff <= in_cell_bin;
         end
         pgmb_pkg::OP_SQX:  sqx_ff <= (2*MW)'(ax) * (2*MW)'(ax);
         pgmb_pkg::OP_SQY:  sqy_ff <= (2*MW)'(ay) * (2*MW)'(ay);
         pgmb_pkg::OP_D2:   d2_ff  <= sqx_ff + sqy_ff;
         pgmb_pkg::OP_RMIN: begin
            rmin2_ff <= (2*RW)'(min_range_ff) * (2*RW)'(min_range_ff);
            brmin_ff <= BRM_W'(min_range_ff) * BRM_W'(BINS);
            span_ff  <= max_range_ff - min_range_ff;
         end
         pgmb_pkg::OP_RMAX: rmax2_ff <= (2*RW)'(max_range_ff) * (2*RW)'(max_range_ff);
         pgmb_pkg::OP_SLO:  slo_ff <= (2*MW)'(d2_ff[MW-1:0]) * (2*MW)'(BINSQ);
         pgmb_pkg::OP_SHI:  shi_ff <= (2*MW)'(d2_ff[2*MW-1:MW]) * (2*MW)'(BINSQ);
         pgmb_pkg::OP_SCALE: begin
            scaled_ff <= {shi_ff, {MW{1'b0}}} + SC_W'(slo_ff);
            lo_ff     <= '0;
            hi_ff     <= BIN_BITS'(BINS - 1);
         end
         pgmb_pkg::OP_EDGE: edge_ff <= EDGE_W'(mid) * EDGE_W'(span_ff) + EDGE_W'(brmin_ff);
         pgmb_pkg::OP_ESQ:  esq_ff  <= (2*EDGE_W)'(edge_ff) * (2*EDGE_W)'(edge_ff);
         pgmb_pkg::OP_STEP: begin
            if (scaled_ff >= SC_W'(esq_ff)) lo_ff <= mid;
            else                            hi_ff <= mid - 1'b1;
         end
         default: ;
      endcase
   end

   // angle unit
   logic                         cordic_done;
   logic [pgmb_pkg::PHASE_W-1:0] phase;

   pgmb_cordic #(.COORD_BITS(COORD_BITS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (op == pgmb_pkg::OP_LOAD && !in_command),
      .x_in  (in_x),
      .y_in  (in_y),
      .done  (cordic_done),
      .phase (phase)
   );

   logic [CHP_W-1:0] ch_prod;
   logic [CHX_W-1:0] chx;
   logic             ch_ok, in_grid;

   assign ch_prod = CHP_W'(phase) * CHP_W'(CHANNELS);
   assign chx     = ch_prod[CHP_W-1:32];
   assign ch_ok   = chx < CHX_W'(CHANNELS);
   assign in_grid = (32'(cch_ff) < 32'(CHANNELS)) && (32'(cbin_ff) < 32'(BINS));

   // cell memory: {valid, lowest z}
   logic [HW:0]        mem [DEPTH];
   logic [HW:0]        rd_ff, wdata;
   logic [ADDR_W-1:0]  addr_ff, clr_ff, waddr;
   logic               we;
   logic signed [32:0] zx;
   logic signed [HW-1:0] zsat, rd_z;

   assign zx   = 33'(z_ff);
   assign zsat = (zx > 33'sd32767)  ? pgmb_pkg::HEIGHT_EMPTY :
                 (zx < -33'sd32768) ? -16'sd32768 : HW'(zx);
   assign rd_z = $signed(rd_ff[HW-1:0]);

   always_comb begin
      we    = 1'b0;
      waddr = addr_ff;
      wdata = {1'b1, zsat};
      if (op == pgmb_pkg::OP_CLEAR) begin
         we    = 1'b1;
         waddr = clr_ff;
         wdata = {1'b0, pgmb_pkg::HEIGHT_EMPTY};
      end else if (op == pgmb_pkg::OP_WRITE) begin
         if (read_ff) begin
            we    = in_grid;
            wdata = {1'b0, pgmb_pkg::HEIGHT_EMPTY};
         end else begin
            we = !rd_ff[HW] || (zsat < rd_z);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (op == pgmb_pkg::OP_READ) rd_ff <= mem[addr_ff];
      if (op == pgmb_pkg::OP_ADDR) begin
         addr_ff <= read_ff ?
                    ADDR_W'(cch_ff) * ADDR_W'(BINS) + ADDR_W'(cbin_ff) :
                    ADDR_W'(chx) * ADDR_W'(BINS) + ADDR_W'(lo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)                         clr_ff <= '0;
      else if (op == pgmb_pkg::OP_CLEAR) clr_ff <= clr_ff + 1'b1;
   end

   // result register
   logic                 vld, ok;
   logic signed [HW-1:0] low, ground;
   logic [31:0]          chx32, lo32;
   logic [pgmb_pkg::RSP_W-1:0] rsp_ff;

   assign vld   = in_grid && rd_ff[HW];
   assign ok    = !out_range && ch_ok;
   assign chx32 = 32'(chx);
   assign lo32  = 32'(lo_ff);
   assign low   = vld ? rd_z : pgmb_pkg::HEIGHT_EMPTY;

   always_comb begin
      if (!vld)                                    ground = sensor_ff;
      else if (low > floor_ff && low < ceiling_ff) ground = low;
      else if (low > ceiling_ff)                   ground = sensor_ff;
      else                                         ground = floor_ff;
   end

   always_ff @(posedge clock) begin
      if (op == pgmb_pkg::OP_RESULT) begin
         if (read_ff) begin
            rsp_ff <= {!vld, ground, low, cbin_ff, cch_ff, 1'b1};
         end else if (ok) begin
            rsp_ff <= {1'b0, 32'd0, lo32[6:0], chx32[6:0], 1'b1};
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign rsp_data = rsp_ff;

   assign status.is_read     = read_ff;
   assign status.out_range   = out_range;
   assign status.search_done = (lo_ff == hi_ff);
   assign status.cordic_done = cordic_done;
   assign status.ch_ok       = ch_ok;
   assign status.clear_last  = (clr_ff == ADDR_W'(DEPTH - 1));
endmodule

// ===== design/pgmb_ctrl.sv =====
// Controller state machine: sequences the datapath one request at a time.
// Issues dp_cmd_type, reads dp_status_type. Depends on pgmb_pkg.
module pgmb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  pgmb_pkg::dp_status_type status,
   output pgmb_pkg::dp_cmd_type    cmd
);
   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_SQX, S_SQY, S_D2, S_RMIN, S_RMAX, S_RTEST,
      S_SLO, S_SHI, S_SCALE, S_CHECK, S_EDGE, S_ESQ, S_STEP, S_WAITC,
      S_ADDR, S_RD, S_WR, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = pgmb_pkg::OP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = pgmb_pkg::OP_CLEAR;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) begin
            cmd.op   = pgmb_pkg::OP_LOAD;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: state_in = status.is_read ? S_ADDR : S_SQX;
         S_SQX:   begin cmd.op = pgmb_pkg::OP_SQX;  state_in = S_SQY;   end
         S_SQY:   begin cmd.op = pgmb_pkg::OP_SQY;  state_in = S_D2;    end
         S_D2:    begin cmd.op = pgmb_pkg::OP_D2;   state_in = S_RMIN;  end
         S_RMIN:  begin cmd.op = pgmb_pkg::OP_RMIN; state_in = S_RMAX;  end
         S_RMAX:  begin cmd.op = pgmb_pkg::OP_RMAX; state_in = S_RTEST; end
         S_RTEST: state_in = status.out_range ? S_OUT : S_SLO;
         S_SLO:   begin cmd.op = pgmb_pkg::OP_SLO;   state_in = S_SHI;   end
         S_SHI:   begin cmd.op = pgmb_pkg::OP_SHI;   state_in = S_SCALE; end
         S_SCALE: begin cmd.op = pgmb_pkg::OP_SCALE; state_in = S_CHECK; end
         S_CHECK: state_in = status.search_done ? S_WAITC : S_EDGE;
         S_EDGE:  begin cmd.op = pgmb_pkg::OP_EDGE; state_in = S_ESQ;   end
         S_ESQ:   begin cmd.op = pgmb_pkg::OP_ESQ;  state_in = S_STEP;  end
         S_STEP:  begin cmd.op = pgmb_pkg::OP_STEP; state_in = S_CHECK; end
         S_WAITC: if (status.cordic_done) state_in = status.ch_ok ? S_ADDR : S_OUT;
         S_ADDR:  begin cmd.op = pgmb_pkg::OP_ADDR;  state_in = S_RD;  end
         S_RD:    begin cmd.op = pgmb_pkg::OP_READ;  state_in = S_WR;  end
         S_WR:    begin cmd.op = pgmb_pkg::OP_WRITE; state_in = S_OUT; end
         S_OUT: if (slot_free) begin
            cmd.op       = pgmb_pkg::OP_RESULT;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== bench/binner_checker.sv =====
// Watches the request, response and register channels of the binner.
// Holds a private copy of the grid and registers, predicts each response
// and compares it; depends on pgmb_pkg.
module binner_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = 128;
   localparam int NBN = 128;

   typedef struct packed {
      logic        cell_empty;
      logic [15:0] ground_height;
      logic [15:0] lowest_height;
      logic [6:0]  bin_index;
      logic [6:0]  channel_index;
      logic        accepted;
   } cell_result_type;

   cell_result_type expected_results[$];
   shortint      lowest_z[NCH*NBN];
   bit           cell_hit[NCH*NBN];
   int unsigned  rng_min, rng_max;
   int           h_floor, h_ceil, h_sensor;

   assign pending_count = expected_results.size();

   // Angle in 2^-32 turns, offset so the result covers [0, 2^32].
   function automatic longint turn_angle(longint x, longint y);
      longint base, a, xs, ys, u;
      base = 0;
      a = 0;
      if (y == 0) return (x >= 0) ? 64'h80000000 : 64'h100000000;
      if (x < 0) begin
         x = -x;
         y = -y;
         base = (y < 0) ? 64'sh80000000 : -64'sh80000000;
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < pgmb_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; a = a + longint'(pgmb_pkg::ANGLE_TAB[i]);
         end else begin
            x = x - ys; y = y + xs; a = a - longint'(pgmb_pkg::ANGLE_TAB[i]);
         end
      end
      u = base + a + 64'sh80000000;
      if (u < 0) u = 0;
      if (u > 64'shFFFFFFFF) u = 64'shFFFFFFFF;
      return u;
   endfunction

   function automatic int ground_of(bit hit, int z);
      if (!hit) return h_sensor;
      if (z > h_floor && z < h_ceil) return z;
      if (z > h_ceil) return h_sensor;
      return h_floor;
   endfunction

   function automatic cell_result_type bin_point(bit is_read, logic [63:0] d);
      cell_result_type r;
      longint x, y, z, d2, span, edge_v, lo, hi, mid, ch;
      int idx, low;
      bit hit;
      r = '0;
      if (is_read) begin
         idx = int'(d[54:48]) * NBN + int'(d[61:55]);
         hit = cell_hit[idx];
         low = hit ? int'(lowest_z[idx]) : 32767;
         cell_hit[idx] = 0;
         lowest_z[idx] = 16'sh7FFF;
         r.accepted = 1;
         r.channel_index = d[54:48];
         r.bin_index = d[61:55];
         r.lowest_height = 16'(low);
         r.ground_height = 16'(ground_of(hit, low));
         r.cell_empty = !hit;
         return r;
      end
      x = longint'($signed(d[15:0]));
      y = longint'($signed(d[31:16]));
      z = longint'($signed(d[47:32]));
      d2 = x * x + y * y;
      if (d2 <= longint'(rng_min) * rng_min || d2 >= longint'(rng_max) * rng_max) return r;
      span = longint'(rng_max) - rng_min;
      lo = 0;
      hi = NBN - 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         edge_v = mid * span + longint'(NBN) * rng_min;
         if (longint'(NBN) * NBN * d2 >= edge_v * edge_v) lo = mid;
         else hi = mid - 1;
      end
      ch = (turn_angle(x, y) * NCH) >>> 32;
      if (ch >= NCH) return r;
      idx = int'(ch) * NBN + int'(lo);
      if (!cell_hit[idx] || z < lowest_z[idx]) begin
         lowest_z[idx] = shortint'(z);
         cell_hit[idx] = 1;
      end
      r.accepted = 1;
      r.channel_index = 7'(ch);
      r.bin_index = 7'(lo);
      return r;
   endfunction

   always @(posedge clock) begin
      cell_result_type want, got;
      if (reset) begin
         for (int i = 0; i < NCH*NBN; i++) begin
            lowest_z[i] = 16'sh7FFF;
            cell_hit[i] = 0;
         end
         rng_min = 32'(pgmb_pkg::MIN_RANGE_RST);
         rng_max = 32'(pgmb_pkg::MAX_RANGE_RST);
         h_floor = int'(pgmb_pkg::FLOOR_RST);
         h_ceil = int'(pgmb_pkg::CEILING_RST);
         h_sensor = int'(pgmb_pkg::SENSOR_RST);
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (pgmb_pkg::csr_reg_type'(csr_index))
               pgmb_pkg::REG_MIN_RANGE: rng_min = 32'(csr_data[14:0]);
               pgmb_pkg::REG_MAX_RANGE: rng_max = 32'(csr_data[14:0]);
               pgmb_pkg::REG_FLOOR:     h_floor = int'($signed(csr_data));
               pgmb_pkg::REG_CEILING:   h_ceil = int'($signed(csr_data));
               pgmb_pkg::REG_SENSOR:    h_sensor = int'($signed(csr_data));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(), bin_point(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.accepted !== want.accepted) begin
                  $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
                  fail_count++;
               end
               if (got.channel_index !== want.channel_index) begin
                  $error("channel_index: expected %0d actual %0d",
                         want.channel_index, got.channel_index);
                  fail_count++;
               end
               if (got.bin_index !== want.bin_index) begin
                  $error("bin_index: expected %0d actual %0d", want.bin_index, got.bin_index);
                  fail_count++;
               end
               if (got.lowest_height !== want.lowest_height) begin
                  $error("lowest_height: expected %0d actual %0d",
                         $signed(want.lowest_height), $signed(got.lowest_height));
                  fail_count++;
               end
               if (got.ground_height !== want.ground_height) begin
                  $error("ground_height: expected %0d actual %0d",
                         $signed(want.ground_height), $signed(got.ground_height));
                  fail_count++;
               end
               if (got.cell_empty !== want.cell_empty) begin
                  $error("cell_empty: expected %0d actual %0d", want.cell_empty, got.cell_empty);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ===== bench/tb_top.sv =====
// Top of the binner bench: clock, reset, request and register stimulus, verdict.
// Depends on pgmb_pkg, polar_grid_min_height_binner and binner_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 60000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   int fail_count, pending_count;
   int send_idle_pct = 0, recv_stall_pct = 0;
   bit recv_hold = 0, hold_request = 0;
   int quiet_cycles = 0;

   // cells that have shown up in responses, so reads mostly hit live cells
   logic [13:0] seen_cells[64];
   int          seen_count = 0;

   polar_grid_min_height_binner uut (.*);

   binner_checker chk (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // receiver: random stall, or a full hold while a long hold-off is running
   always @(posedge clock)
      rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);

   // long hold-off counted here so the sender keeps pushing and the block backs up
   always @(posedge clock) begin
      if (hold_request && !recv_hold) begin
         recv_hold = 1;
         repeat (400) @(posedge clock);
         recv_hold = 0;
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && rsp_tdata[0]) begin
         seen_cells[seen_count % 64] <= rsp_tdata[14:1];
         seen_count <= seen_count + 1;
      end
   end

   // watchdog: any handshake counts as progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_request(bit is_read, logic [63:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= is_read;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic insert_point(int x, int y, int z);
      send_request(0, {2'b0, 14'd0, 16'(z), 16'(y), 16'(x)});
   endtask

   task automatic read_cell(logic [6:0] ch, logic [6:0] bn);
      send_request(1, {2'b0, bn, ch, 48'b0});
   endtask

   task automatic read_seen_cell();
      logic [13:0] c;
      c = (seen_count == 0) ? 14'($urandom) : seen_cells[$urandom_range(63) % 64];
      if (seen_count > 0 && seen_count < 64) c = seen_cells[$urandom_range(seen_count - 1)];
      read_cell(c[6:0], c[13:7]);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(pgmb_pkg::csr_reg_type idx, logic [15:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic load_setting(int sel);
      int lo;
      case (sel)
         0: begin
            write_reg(pgmb_pkg::REG_MIN_RANGE, 16'd340);
            write_reg(pgmb_pkg::REG_MAX_RANGE, 16'd12000);
            write_reg(pgmb_pkg::REG_FLOOR, -16'sd200);
            write_reg(pgmb_pkg::REG_CEILING, -16'sd40);
            write_reg(pgmb_pkg::REG_SENSOR, 16'sd200);
         end
         1: begin
            write_reg(pgmb_pkg::REG_MIN_RANGE, 16'd0);
            write_reg(pgmb_pkg::REG_MAX_RANGE, 16'd32767);
            write_reg(pgmb_pkg::REG_FLOOR, 16'h8000);
            write_reg(pgmb_pkg::REG_CEILING, 16'h7FFF);
            write_reg(pgmb_pkg::REG_SENSOR, 16'h8000);
         end
         2: begin
            // empty window: max below min, nothing gets in
            write_reg(pgmb_pkg::REG_MIN_RANGE, 16'd32767);
            write_reg(pgmb_pkg::REG_MAX_RANGE, 16'd1);
            write_reg(pgmb_pkg::REG_FLOOR, 16'h7FFF);
            write_reg(pgmb_pkg::REG_CEILING, 16'h8000);
            write_reg(pgmb_pkg::REG_SENSOR, 16'h7FFF);
         end
         default: begin
            lo = $urandom_range(2000);
            write_reg(pgmb_pkg::REG_MIN_RANGE, 16'(lo));
            write_reg(pgmb_pkg::REG_MAX_RANGE, 16'(lo + 1 + $urandom_range(14000)));
            write_reg(pgmb_pkg::REG_FLOOR, 16'($urandom_range(400) - 500));
            write_reg(pgmb_pkg::REG_CEILING, 16'($urandom_range(300) - 150));
            write_reg(pgmb_pkg::REG_SENSOR, 16'($urandom));
         end
      endcase
   endtask

   task automatic random_item();
      int r, x, y, z;
      r = $urandom_range(99);
      if (r < 30) begin
         if ($urandom_range(9) == 0) read_cell(7'($urandom), 7'($urandom));
         else read_seen_cell();
      end else begin
         if (r < 88) begin
            x = int'($urandom_range(26000)) - 13000;
            y = int'($urandom_range(26000)) - 13000;
         end else begin
            x = int'($signed(16'($urandom)));
            y = ($urandom_range(3) == 0) ? 0 : int'($signed(16'($urandom)));
         end
         z = ($urandom_range(1) == 0) ? int'($signed(16'($urandom)))
                                      : int'($urandom_range(500)) - 350;
         insert_point(x, y, z);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: extremes, axes, range edges, empty and live cell reads
      read_cell(7'd0, 7'd0);
      read_cell(7'd127, 7'd127);
      insert_point(0, 0, 0);
      insert_point(340, 0, -100);
      insert_point(341, 0, -100);
      insert_point(11999, 0, -300);
      insert_point(12000, 0, -300);
      insert_point(-5000, 0, -120);
      insert_point(0, 5000, 50);
      insert_point(0, -5000, -32768);
      insert_point(-5000, 1, 32767);
      insert_point(-5000, -1, -60);
      insert_point(32767, 32767, -150);
      insert_point(-32768, -32768, -150);
      insert_point(-3000, 4000, -150);
      insert_point(-3000, 4000, -180);
      insert_point(3000, -4000, -40);
      insert_point(3000, 4000, -200);
      insert_point(4242, 4242, 16'h7FFF);
      drain();
      repeat (8) read_seen_cell();
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         load_setting(phase);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            3: begin send_idle_pct = 28; recv_stall_pct = 28; end
            4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         for (int n = 0; n < 150; n++) begin
            if (phase == 4 && n == 20) hold_request = 1;
            if (recv_hold) hold_request = 0;
            random_item();
         end
         hold_request = 0;
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
